@@ rtl/core/sbs_pkg.sv @@
`default_nettype none

package sbs_pkg;

  // fixed field widths of the stream and register ports
  localparam int unsigned POS_W      = 11;
  localparam int unsigned IDX_IN_W   = 10;
  localparam int unsigned KEY_IN_W   = 32;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 16;

  // word index of the entries_in_use register (paddr bit 2)
  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  // item kinds carried in the slave tuser
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_LOWER = 2'd1,
    OP_UPPER = 2'd2,
    OP_FIND  = 2'd3
  } op_e;

  // search engine states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } st_e;

endpackage

`default_nettype wire

@@ rtl/core/sbs_front.sv @@
`default_nettype none

module sbs_front #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // register port
  input  wire logic                             psel_i,
  input  wire logic                             penable_i,
  input  wire logic                             pwrite_i,
  input  wire logic [sbs_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  wire logic [sbs_pkg::APB_DATA_W-1:0]   pwdata_i,
  output logic      [sbs_pkg::APB_DATA_W-1:0]   prdata_o,
  // input stream
  input  wire logic                             s_tvalid_i,
  output logic                                  s_tready_o,
  input  wire logic [sbs_pkg::S_TDATA_W-1:0]    s_tdata_i,
  input  wire logic [1:0]                       s_tuser_i,
  // command queue side
  output logic                                  push_valid_o,
  input  wire logic                             push_ready_i,
  output logic [2+$clog2(TABLE_DEPTH)+VALUE_WIDTH-1:0] cmd_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]      count_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [sbs_pkg::CFG_W-1:0]    entries_q, entries_d;
  logic                         cfg_we;
  sbs_pkg::op_e                 op;
  logic [sbs_pkg::IDX_IN_W-1:0] in_idx;
  logic [sbs_pkg::KEY_IN_W-1:0] in_val;
  logic [VALUE_WIDTH-1:0]       word;
  logic                         in_range;
  logic                         keep;

  // entries_in_use register
  assign cfg_we = psel_i && penable_i && pwrite_i &&
                  (paddr_i[2] == sbs_pkg::REG_ENTRIES_IN_USE);
  assign entries_d = cfg_we ? pwdata_i[sbs_pkg::CFG_W-1:0] : entries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else begin
      entries_q <= entries_d;
    end
  end

  assign prdata_o = (paddr_i[2] == sbs_pkg::REG_ENTRIES_IN_USE) ?
                    sbs_pkg::APB_DATA_W'(entries_q) : '0;

  // searched count saturates at the table depth
  always_comb begin
    if (32'(entries_q) > 32'(TABLE_DEPTH)) begin
      count_o = CNT_W'(TABLE_DEPTH);
    end else begin
      count_o = CNT_W'(entries_q);
    end
  end

  // classify the item
  assign op       = sbs_pkg::op_e'(s_tuser_i);
  assign in_idx   = s_tdata_i[sbs_pkg::IDX_IN_W-1:0];
  assign in_val   = s_tdata_i[sbs_pkg::IDX_IN_W +: sbs_pkg::KEY_IN_W];
  assign word     = VALUE_WIDTH'($signed(in_val));
  assign in_range = 32'(in_idx) < 32'(TABLE_DEPTH);

  // loads beyond the table are taken and dropped here
  always_comb begin
    unique case (op)
      sbs_pkg::OP_LOAD:  keep = in_range;
      sbs_pkg::OP_LOWER,
      sbs_pkg::OP_UPPER,
      sbs_pkg::OP_FIND:  keep = 1'b1;
      default:           keep = 1'b1;
    endcase
  end

  assign s_tready_o   = push_ready_i;
  assign push_valid_o = s_tvalid_i && keep;
  assign cmd_o        = {op, IDX_W'(in_idx), word};

endmodule

`default_nettype wire

@@ rtl/core/sbs_queue.sv @@
`default_nettype none

module sbs_queue #(
  parameter int unsigned WIDTH = 44
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;
  logic             push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sbs_back.sv @@
`default_nettype none

module sbs_back #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // command queue side
  input  wire logic                              cmd_valid_i,
  output logic                                   cmd_ready_o,
  input  wire logic [2+$clog2(TABLE_DEPTH)+VALUE_WIDTH-1:0] cmd_i,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]  count_i,
  // result stream
  output logic                                   m_tvalid_o,
  input  wire logic                              m_tready_i,
  output logic [sbs_pkg::POS_W-1:0]              m_pos_o,
  output logic                                   m_found_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  sbs_pkg::st_e           state_q, state_d;
  sbs_pkg::op_e           kind_q, kind_d;
  logic [CNT_W-1:0]       lo_q, lo_d;
  logic [CNT_W-1:0]       hi_q, hi_d;
  logic [CNT_W-1:0]       mid_q, mid_d;
  logic                   hit_q, hit_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic                   out_valid_q, out_valid_d;
  logic [sbs_pkg::POS_W-1:0] out_pos_q, out_pos_d;
  logic                   out_found_q, out_found_d;

  logic [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_q;

  sbs_pkg::op_e           cmd_op;
  logic [IDX_W-1:0]       cmd_idx;
  logic [VALUE_WIDTH-1:0] cmd_word;
  logic                   mem_we;
  logic [CNT_W-1:0]       span;
  logic [CNT_W-1:0]       probe;
  logic                   w_lt, w_eq, go_right;
  logic                   out_free;

  assign cmd_op   = sbs_pkg::op_e'(cmd_i[VALUE_WIDTH+IDX_W +: 2]);
  assign cmd_idx  = cmd_i[VALUE_WIDTH +: IDX_W];
  assign cmd_word = cmd_i[VALUE_WIDTH-1:0];
  assign out_free = !out_valid_q || m_tready_i;

  // probe point: halving over [lo, hi) for bounds, over [lo, hi-1] for find
  always_comb begin
    span = hi_q - lo_q;
    if (kind_q == sbs_pkg::OP_FIND) begin
      span = span - CNT_W'(1);
    end
    probe = lo_q + (span >> 1);
  end

  // compare the registered table word with the key
  assign w_lt = $signed(rd_q) < $signed(key_q);
  assign w_eq = (rd_q == key_q);
  assign go_right = (kind_q == sbs_pkg::OP_UPPER) ? (w_lt || w_eq) : w_lt;

  // search sequencer
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    hit_d       = hit_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_pos_d   = out_pos_q;
    out_found_d = out_found_q;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;

    unique case (state_q)
      sbs_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_op == sbs_pkg::OP_LOAD) begin
            mem_we = 1'b1;
          end else begin
            kind_d  = cmd_op;
            key_d   = cmd_word;
            lo_d    = '0;
            hi_d    = count_i;
            hit_d   = 1'b0;
            state_d = (count_i != '0) ? sbs_pkg::ST_READ : sbs_pkg::ST_DONE;
          end
        end
      end
      sbs_pkg::ST_READ: begin
        mid_d   = probe;
        state_d = sbs_pkg::ST_CMP;
      end
      sbs_pkg::ST_CMP: begin
        if (kind_q == sbs_pkg::OP_FIND && w_eq) begin
          hit_d   = 1'b1;
          state_d = sbs_pkg::ST_DONE;
        end else begin
          if (go_right) begin
            lo_d = mid_q + CNT_W'(1);
          end else begin
            hi_d = mid_q;
          end
          state_d = (lo_d < hi_d) ? sbs_pkg::ST_READ : sbs_pkg::ST_DONE;
        end
      end
      sbs_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (kind_q == sbs_pkg::OP_FIND) begin
            out_pos_d   = hit_q ? sbs_pkg::POS_W'(mid_q) : '0;
            out_found_d = hit_q;
          end else begin
            out_pos_d   = sbs_pkg::POS_W'(lo_q);
            out_found_d = 1'b1;
          end
          state_d = sbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sbs_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // search and result payload
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    hit_q       <= hit_d;
    key_q       <= key_d;
    out_pos_q   <= out_pos_d;
    out_found_q <= out_found_d;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[cmd_idx] <= cmd_word;
    end
    rd_q <= table_mem[probe[IDX_W-1:0]];
  end

  assign m_tvalid_o = out_valid_q;
  assign m_pos_o    = out_pos_q;
  assign m_found_o  = out_found_q;

endmodule

`default_nettype wire

@@ rtl/core/sorted_table_bound_search.sv @@
// Sorted table bound search. Software loads signed words in ascending order
// into the table with load items (kind 0), sets entries_in_use over the
// register port, then issues lower bound (1), upper bound (2) or exact find
// (3) items; each query returns one result item, a load returns none and a
// load beyond the table is dropped. A load is written as the engine takes it.
// A query is taken in the idle state and, unless the count is zero, runs one
// probe after another, each a registered table read and then a compare, and
// ends in a done state that loads the result register once that register is
// free; an exact find stops at its first match. Items queue in a two-entry
// buffer ahead of the engine and results leave through an output register,
// so input and output stall independently. The table has no reset: entries
// must be loaded before they are searched.
`default_nettype none

module sorted_table_bound_search #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sbs_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [sbs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [sbs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // entry_index [9:0], search_value [41:10], zero [47:42]
  input  wire logic [sbs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // operation [1:0]
  input  wire logic [1:0]                        s_axis_tuser,
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // position [10:0], zero [15:11]
  output logic [sbs_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  // found [0]
  output logic [0:0]                             m_axis_tuser
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMD_W = 2 + IDX_W + VALUE_WIDTH;

  logic                      push_valid, push_ready;
  logic [CMD_W-1:0]          push_cmd;
  logic                      pop_valid, pop_ready;
  logic [CMD_W-1:0]          pop_cmd;
  logic [CNT_W-1:0]          count;
  logic [sbs_pkg::POS_W-1:0] res_pos;
  logic                      res_found;

  assign pready = 1'b1;

  // front: register port and item classification
  sbs_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_o     (prdata),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .cmd_o        (push_cmd),
    .count_o      (count)
  );

  // command queue between front and engine
  sbs_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_cmd)
  );

  // back: table memory and binary search engine
  sbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .count_i     (count),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_pos_o     (res_pos),
    .m_found_o   (res_found)
  );

  assign m_axis_tdata = sbs_pkg::M_TDATA_W'(res_pos);
  assign m_axis_tuser = res_found;

endmodule

`default_nettype wire

@@ rtl/core/sbs_checker.sv @@
`default_nettype none

module sbs_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic [sbs_pkg::APB_ADDR_W-1:0] paddr,
  input wire logic [sbs_pkg::APB_DATA_W-1:0] pwdata,
  input wire logic [sbs_pkg::APB_DATA_W-1:0] prdata,
  input wire logic                           pready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [sbs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input wire logic [0:0]                     m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss with nonzero position");

  // the register port never waits
  a_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  // a written count reads back
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2] |->
      prdata == sbs_pkg::APB_DATA_W'($past(pwdata[sbs_pkg::CFG_W-1:0])))
    else $error("entries_in_use read back mismatch");

endmodule

bind sorted_table_bound_search sbs_checker u_sbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/sorted_table_bound_search_tb.sv @@
module sorted_table_bound_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 1024;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int DIR_ROWS     = 24;

  localparam logic signed [31:0] MIN_WORD = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_WORD = 32'sh7fff_ffff;

  // register addresses: entries_in_use, and a word with no register behind it
  localparam logic [sbs_pkg::APB_ADDR_W-1:0] ENTRIES_ADDR =
    {sbs_pkg::REG_ENTRIES_IN_USE, 2'b00};
  localparam logic [sbs_pkg::APB_ADDR_W-1:0] SPARE_ADDR   = 3'd4;
  localparam logic [9:0] ENTRIES_ROW = 10'(ENTRIES_ADDR);
  localparam logic [9:0] SPARE_ROW   = 10'(SPARE_ADDR);

  typedef struct packed {
    logic [sbs_pkg::POS_W-1:0] pos;
    logic                      found;
  } answer_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // on config rows idx carries the register address and word the data
  typedef struct packed {
    row_kind_e          kind;
    sbs_pkg::op_e       op;
    logic [9:0]         idx;
    logic signed [31:0] word;
    logic               typed;
    answer_t            ans;
  } row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [sbs_pkg::APB_ADDR_W-1:0] paddr;
  logic [sbs_pkg::APB_DATA_W-1:0] pwdata;
  logic [sbs_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [sbs_pkg::S_TDATA_W-1:0]  s_axis_tdata;
  logic [1:0]                     s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [sbs_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic [0:0]                     m_axis_tuser;

  // shadow of the block: table words and the searched entry count
  logic signed [31:0]        shadow_words [TABLE_DEPTH];
  logic [sbs_pkg::CFG_W-1:0] shadow_count;
  answer_t                   expected_answers [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_request;
  int  err_count;
  int  loads_sent;
  int  queries_sent;
  int  results_seen;
  int  cfg_writes;
  int  quiet_cycles;
  row_t rows [DIR_ROWS];

  sorted_table_bound_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // binary search over the shadow table, bounds half open, find inclusive
  function automatic answer_t search_answer(sbs_pkg::op_e op, logic signed [31:0] key);
    int     lo;
    int     hi;
    int     mid;
    bit     go_right;
    answer_t a;
    lo = 0;
    hi = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    a.pos = '0;
    a.found = 1'b1;
    if (op == sbs_pkg::OP_FIND) begin
      a.found = 1'b0;
      while (lo < hi) begin
        mid = lo + (hi - 1 - lo) / 2;
        if (shadow_words[mid] == key) begin
          a.pos = mid[sbs_pkg::POS_W-1:0];
          a.found = 1'b1;
          return a;
        end
        if (shadow_words[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return a;
    end
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (op == sbs_pkg::OP_UPPER) go_right = (shadow_words[mid] <= key);
      else go_right = (shadow_words[mid] < key);
      if (go_right) lo = mid + 1;
      else hi = mid;
    end
    a.pos = lo[sbs_pkg::POS_W-1:0];
    return a;
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(9, 0))
      0: pick_word = MIN_WORD;
      1: pick_word = MAX_WORD;
      2, 3, 4: pick_word = $signed($urandom_range(40, 0)) - 20;
      default: pick_word = $urandom();
    endcase
  endfunction

  function automatic row_t mk_row(row_kind_e kind, sbs_pkg::op_e op, logic [9:0] idx,
                                  logic signed [31:0] word, logic typed,
                                  logic [sbs_pkg::POS_W-1:0] pos, logic found);
    row_t r;
    r.kind = kind;
    r.op = op;
    r.idx = idx;
    r.word = word;
    r.typed = typed;
    r.ans.pos = pos;
    r.ans.found = found;
    return r;
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // offer one item, called at a falling edge, returns at a falling edge once the item is taken
  task automatic send_item(sbs_pkg::op_e op, logic [9:0] idx, logic signed [31:0] word,
                           logic typed, answer_t typed_ans);
    answer_t ans;
    if ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, word, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == sbs_pkg::OP_LOAD) begin
      shadow_words[idx] = word;
      loads_sent++;
    end else begin
      ans = search_answer(op, word);
      if (typed) ans = typed_ans;
      expected_answers.push_back(ans);
      queries_sent++;
    end
    @(negedge clk_i);
  endtask

  // let every result come back and trailing loads retire
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // register write, then read back entries_in_use
  task automatic write_register(logic [sbs_pkg::APB_ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ENTRIES_ADDR) shadow_count = data[sbs_pkg::CFG_W-1:0];
    cfg_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ENTRIES_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[sbs_pkg::CFG_W-1:0] !== shadow_count)
      flag_error($sformatf("entries_in_use readback: expected %0d, got %0d",
                           shadow_count, prdata[sbs_pkg::CFG_W-1:0]));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // set the count, load a fresh table (mostly ascending), then query it
  task automatic run_phase(logic [31:0] cfg_word, int load_count, int n_queries,
                           bit with_hold);
    logic signed [31:0] fresh [TABLE_DEPTH];
    logic signed [31:0] w;
    logic signed [31:0] key;
    bit   keep_order;
    int   j;
    int   off;
    int   active;
    sbs_pkg::op_e op;
    wait_quiet();
    write_register(ENTRIES_ADDR, cfg_word);
    keep_order = ($urandom_range(7, 0) != 0);
    for (int i = 0; i < load_count; i++) begin
      if (i > 0 && $urandom_range(3, 0) == 0) w = fresh[$urandom_range(i - 1, 0)];
      else w = pick_word();
      j = i;
      if (keep_order) begin
        while (j > 0 && fresh[j - 1] > w) begin
          fresh[j] = fresh[j - 1];
          j--;
        end
      end
      fresh[j] = w;
    end
    for (int i = 0; i < load_count; i++)
      send_item(sbs_pkg::OP_LOAD, i[9:0], fresh[i], 1'b0, '0);
    if (with_hold) hold_request = 1'b1;
    active = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    for (int q = 0; q < n_queries; q++) begin
      // occasional stray load, may break the ordering
      if ($urandom_range(15, 0) == 0) begin
        send_item(sbs_pkg::OP_LOAD, 10'($urandom_range(TABLE_DEPTH - 1, 0)), pick_word(),
                  1'b0, '0);
      end else begin
        op = sbs_pkg::op_e'($urandom_range(3, 1));
        if (active > 0 && $urandom_range(1, 0) == 1) begin
          off = $urandom_range(2, 0);
          key = shadow_words[$urandom_range(active - 1, 0)] + off - 1;
        end else begin
          key = pick_word();
        end
        send_item(op, 10'($urandom_range(TABLE_DEPTH - 1, 0)), key, 1'b0, '0);
      end
    end
  endtask

  // result sink with random back pressure and a long hold on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // compare each result with the oldest expected answer
  always @(posedge clk_i) begin : result_check
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_answers.size() == 0) begin
        flag_error($sformatf("unexpected result: position %0d found %0d",
                             m_axis_tdata[sbs_pkg::POS_W-1:0], m_axis_tuser[0]));
      end else begin
        want = expected_answers.pop_front();
        if (want.pos !== m_axis_tdata[sbs_pkg::POS_W-1:0] ||
            want.found !== m_axis_tuser[0])
          flag_error($sformatf({"result mismatch: expected position %0d found %0d,",
                                " got position %0d found %0d"},
                               want.pos, want.found, m_axis_tdata[sbs_pkg::POS_W-1:0],
                               m_axis_tuser[0]));
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = sbs_pkg::OP_LOAD;
    hold_request  = 1'b0;
    err_count     = 0;
    loads_sent    = 0;
    queries_sent  = 0;
    results_seen  = 0;
    cfg_writes    = 0;
    quiet_cycles  = 0;
    shadow_count  = '0;
    send_idle_pct = 37;
    recv_idle_pct = 46;

    // directed rows: empty table, extremes, repeated key, miss, spare address
    rows[0]  = mk_row(ROW_CFG,  sbs_pkg::OP_LOAD,  ENTRIES_ROW, 32'sd0,  1'b0, 11'd0, 1'b0);
    rows[1]  = mk_row(ROW_ITEM, sbs_pkg::OP_LOWER, 10'd0,    32'sd0,    1'b1, 11'd0, 1'b1);
    rows[2]  = mk_row(ROW_ITEM, sbs_pkg::OP_UPPER, 10'd1023, MAX_WORD,  1'b1, 11'd0, 1'b1);
    rows[3]  = mk_row(ROW_ITEM, sbs_pkg::OP_FIND,  10'd0,    MIN_WORD,  1'b1, 11'd0, 1'b0);
    rows[4]  = mk_row(ROW_ITEM, sbs_pkg::OP_LOAD,  10'd0,    MIN_WORD,  1'b0, 11'd0, 1'b0);
    rows[5]  = mk_row(ROW_ITEM, sbs_pkg::OP_LOAD,  10'd1,    -32'sd5,   1'b0, 11'd0, 1'b0);
    rows[6]  = mk_row(ROW_ITEM, sbs_pkg::OP_LOAD,  10'd2,    -32'sd5,   1'b0, 11'd0, 1'b0);
    rows[7]  = mk_row(ROW_ITEM, sbs_pkg::OP_LOAD,  10'd3,    32'sd7,    1'b0, 11'd0, 1'b0);
    rows[8]  = mk_row(ROW_ITEM, sbs_pkg::OP_LOAD,  10'd4,    MAX_WORD,  1'b0, 11'd0, 1'b0);
    rows[9]  = mk_row(ROW_CFG,  sbs_pkg::OP_LOAD,  SPARE_ROW,   32'sd3,  1'b0, 11'd0, 1'b0);
    rows[10] = mk_row(ROW_CFG,  sbs_pkg::OP_LOAD,  ENTRIES_ROW, 32'sd5,  1'b0, 11'd0, 1'b0);
    rows[11] = mk_row(ROW_ITEM, sbs_pkg::OP_LOWER, 10'd0,    MIN_WORD,  1'b1, 11'd0, 1'b1);
    rows[12] = mk_row(ROW_ITEM, sbs_pkg::OP_UPPER, 10'd0,    MAX_WORD,  1'b1, 11'd5, 1'b1);
    rows[13] = mk_row(ROW_ITEM, sbs_pkg::OP_LOWER, 10'd0,    MAX_WORD,  1'b1, 11'd4, 1'b1);
    rows[14] = mk_row(ROW_ITEM, sbs_pkg::OP_UPPER, 10'd0,    MIN_WORD,  1'b1, 11'd1, 1'b1);
    rows[15] = mk_row(ROW_ITEM, sbs_pkg::OP_LOWER, 10'd0,    -32'sd5,   1'b0, 11'd0, 1'b0);
    rows[16] = mk_row(ROW_ITEM, sbs_pkg::OP_UPPER, 10'd0,    -32'sd5,   1'b0, 11'd0, 1'b0);
    rows[17] = mk_row(ROW_ITEM, sbs_pkg::OP_FIND,  10'd0,    -32'sd5,   1'b0, 11'd0, 1'b0);
    rows[18] = mk_row(ROW_ITEM, sbs_pkg::OP_FIND,  10'd0,    32'sd6,    1'b1, 11'd0, 1'b0);
    rows[19] = mk_row(ROW_ITEM, sbs_pkg::OP_FIND,  10'd1023, MAX_WORD,  1'b0, 11'd0, 1'b0);
    rows[20] = mk_row(ROW_ITEM, sbs_pkg::OP_LOAD,  10'd1023, 32'sd0,    1'b0, 11'd0, 1'b0);
    rows[21] = mk_row(ROW_CFG,  sbs_pkg::OP_LOAD,  ENTRIES_ROW, 32'sd1,  1'b0, 11'd0, 1'b0);
    rows[22] = mk_row(ROW_ITEM, sbs_pkg::OP_FIND,  10'd0,    MIN_WORD,  1'b1, 11'd0, 1'b1);
    rows[23] = mk_row(ROW_ITEM, sbs_pkg::OP_UPPER, 10'd0,    32'sd0,    1'b0, 11'd0, 1'b0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) begin
        wait_quiet();
        write_register(rows[r].idx[sbs_pkg::APB_ADDR_W-1:0], rows[r].word);
      end else begin
        send_item(rows[r].op, rows[r].idx, rows[r].word, rows[r].typed, rows[r].ans);
      end
    end

    // random phases under three idling patterns
    for (int grp = 0; grp < 3; grp++) begin
      case (grp)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 3; ph++) begin
        if ($urandom_range(3, 0) == 0) n = $urandom_range(2, 0);
        else n = $urandom_range(16, 1);
        if ($urandom_range(1, 0) == 1)
          run_phase(($urandom() & 32'hffff_f800) | n, n, $urandom_range(10, 6), ph == 1);
        else
          run_phase(n, n, $urandom_range(10, 6), ph == 1);
      end
    end

    // full table, then an oversized count that saturates to the depth
    run_phase(TABLE_DEPTH, TABLE_DEPTH, 20, 1'b0);
    run_phase(32'd2047, 0, 20, 1'b1);

    wait_quiet();
    $display("covered %0d loads, %0d queries and %0d register writes",
             loads_sent, queries_sent, cfg_writes);
    $display("tables of 0 to %0d entries, %0d results checked, %0d mismatches",
             TABLE_DEPTH, results_seen, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sbs_pkg.sv
rtl/core/sbs_front.sv
rtl/core/sbs_queue.sv
rtl/core/sbs_back.sv
rtl/core/sorted_table_bound_search.sv
rtl/core/sbs_checker.sv
tb/sorted_table_bound_search_tb.sv
